// ----- src/pngcp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngcp_pkg - shared types and constants of the PNG chunk stream parser
// Parse phases, event and chunk kind codes, the queue record passed from the
// front end to the back end, and the signature and type lookups.
// ----------------------------------------------------------------------------
package pngcp_pkg;

   // Parse phases of the front end
   typedef enum logic [2:0] {
      PH_SIG  = 3'd0,
      PH_LEN  = 3'd1,
      PH_TYPE = 3'd2,
      PH_DATA = 3'd3,
      PH_CRC  = 3'd4,
      PH_DONE = 3'd5,
      PH_BAD  = 3'd6
   } phase_type;

   // Result event codes
   localparam logic [1:0] EV_MISMATCH = 2'd0;
   localparam logic [1:0] EV_PAYLOAD  = 2'd1;
   localparam logic [1:0] EV_COMPLETE = 2'd2;

   // Chunk kind codes
   localparam logic [2:0] KIND_IHDR  = 3'd0;
   localparam logic [2:0] KIND_PLTE  = 3'd1;
   localparam logic [2:0] KIND_IDAT  = 3'd2;
   localparam logic [2:0] KIND_IEND  = 3'd3;
   localparam logic [2:0] KIND_OTHER = 3'd4;

   // Chunk type words, big-endian ASCII
   localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
   localparam logic [31:0] TYPE_PLTE = 32'h504C_5445;
   localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
   localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

   // Byte counts of the fixed framing fields
   localparam logic [31:0] SIG_BYTES  = 32'd8;
   localparam logic [31:0] WORD_BYTES = 32'd4;

   // IHDR payload layout: width, height, then five single header bytes
   localparam logic [31:0] IHDR_HEIGHT_AT = 32'd4;
   localparam logic [31:0] IHDR_BYTES_AT  = 32'd8;
   localparam logic [31:0] IHDR_END_AT    = 32'd13;
   localparam int          HDR_BYTES      = 5;

   // Work passed from front end to back end
   typedef enum logic [2:0] {
      OP_NONE     = 3'd0,
      OP_MISMATCH = 3'd1,
      OP_PAYLOAD  = 3'd2,
      OP_COMPLETE = 3'd3,
      OP_WIDTH    = 3'd4,
      OP_HEIGHT   = 3'd5,
      OP_HDR_BYTE = 3'd6
   } op_code_type;

   typedef struct packed {
      op_code_type op;
      logic        clear;
      logic [2:0]  kind;
      logic [31:0] length;
      logic [7:0]  data;
      logic [31:0] crc;
      logic [2:0]  hdr_idx;
   } op_type;

   // One result beat
   typedef struct packed {
      logic [1:0]  event_res;
      logic [2:0]  chunk_kind;
      logic [31:0] chunk_length;
      logic [7:0]  payload_byte;
      logic [31:0] chunk_crc;
      logic [31:0] image_width;
      logic [31:0] image_height;
      logic [7:0]  bit_depth;
      logic [7:0]  color_kind;
      logic [7:0]  compression_method;
      logic [7:0]  filter_method;
      logic [7:0]  interlace_method;
   } rsp_type;

   // Expected signature byte at a given position
   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0:    val = 8'd137;
         3'd1:    val = 8'd80;
         3'd2:    val = 8'd78;
         3'd3:    val = 8'd71;
         3'd4:    val = 8'd13;
         3'd5:    val = 8'd10;
         3'd6:    val = 8'd26;
         3'd7:    val = 8'd10;
         default: val = 8'd0;
      endcase
      return val;
   endfunction

   // Classify a chunk type word
   function automatic logic [2:0] kind_of(input logic [31:0] t);
      logic [2:0] k;
      if (t == TYPE_IHDR) begin
         k = KIND_IHDR;
      end else if (t == TYPE_PLTE) begin
         k = KIND_PLTE;
      end else if (t == TYPE_IDAT) begin
         k = KIND_IDAT;
      end else if (t == TYPE_IEND) begin
         k = KIND_IEND;
      end else begin
         k = KIND_OTHER;
      end
      return k;
   endfunction

endpackage

// ----- src/pngcp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngcp_front - byte framer of the PNG chunk stream parser
// Checks the signature, frames length, type, payload and CRC, and turns each
// byte that leaves work for the back end into a queue record.
// ----------------------------------------------------------------------------
module pngcp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          file_byte,
   input  logic                start_of_file,
   output logic                push,
   output pngcp_pkg::op_type   push_data
);

   pngcp_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [31:0] count_ff, count_in, count_cur, count_plus;
   logic [31:0] len_ff, len_in, len_cur;
   logic [31:0] type_ff, type_in, type_cur;
   logic [31:0] crc_ff, crc_in, crc_cur;
   logic [2:0]  kind_ff, kind_in;
   pngcp_pkg::op_type op;

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pngcp_pkg::PH_SIG;
         count_ff <= '0;
         len_ff   <= '0;
         type_ff  <= '0;
         crc_ff   <= '0;
         kind_ff  <= pngcp_pkg::KIND_OTHER;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         type_ff  <= type_in;
         crc_ff   <= crc_in;
         kind_ff  <= kind_in;
      end
   end

   // Advance the framer by one byte
   always_comb begin
      if (start_of_file) begin
         phase_cur = pngcp_pkg::PH_SIG;
         count_cur = '0;
         len_cur   = '0;
         type_cur  = '0;
         crc_cur   = '0;
      end else begin
         phase_cur = phase_ff;
         count_cur = count_ff;
         len_cur   = len_ff;
         type_cur  = type_ff;
         crc_cur   = crc_ff;
      end
      count_plus = count_cur + 32'd1;

      phase_in = phase_cur;
      count_in = count_cur;
      len_in   = len_cur;
      type_in  = type_cur;
      crc_in   = crc_cur;
      kind_in  = kind_ff;

      op         = '0;
      op.op      = pngcp_pkg::OP_NONE;
      op.clear   = start_of_file;

      case (phase_cur)
         pngcp_pkg::PH_SIG: begin
            if (file_byte != pngcp_pkg::sig_byte(count_cur[2:0])) begin
               phase_in = pngcp_pkg::PH_BAD;
               op.op    = pngcp_pkg::OP_MISMATCH;
            end else if (count_plus == pngcp_pkg::SIG_BYTES) begin
               phase_in = pngcp_pkg::PH_LEN;
               count_in = '0;
               len_in   = '0;
            end else begin
               count_in = count_plus;
            end
         end
         pngcp_pkg::PH_LEN: begin
            len_in = {len_cur[23:0], file_byte};
            if (count_plus == pngcp_pkg::WORD_BYTES) begin
               phase_in = pngcp_pkg::PH_TYPE;
               count_in = '0;
               type_in  = '0;
            end else begin
               count_in = count_plus;
            end
         end
         pngcp_pkg::PH_TYPE: begin
            type_in = {type_cur[23:0], file_byte};
            if (count_plus == pngcp_pkg::WORD_BYTES) begin
               count_in = '0;
               crc_in   = '0;
               kind_in  = pngcp_pkg::kind_of({type_cur[23:0], file_byte});
               phase_in = (len_cur == '0) ? pngcp_pkg::PH_CRC : pngcp_pkg::PH_DATA;
            end else begin
               count_in = count_plus;
            end
         end
         pngcp_pkg::PH_DATA: begin
            op.data   = file_byte;
            op.kind   = kind_ff;
            op.length = len_cur;
            // IHDR fields go to the back end, emitted kinds become payload beats
            if (kind_ff == pngcp_pkg::KIND_IHDR) begin
               if (count_cur < pngcp_pkg::IHDR_HEIGHT_AT) begin
                  op.op = pngcp_pkg::OP_WIDTH;
               end else if (count_cur < pngcp_pkg::IHDR_BYTES_AT) begin
                  op.op = pngcp_pkg::OP_HEIGHT;
               end else if (count_cur < pngcp_pkg::IHDR_END_AT) begin
                  op.op      = pngcp_pkg::OP_HDR_BYTE;
                  op.hdr_idx = count_cur[2:0];
               end
            end else if (kind_ff != pngcp_pkg::KIND_OTHER) begin
               op.op = pngcp_pkg::OP_PAYLOAD;
            end
            if (count_plus == len_cur) begin
               phase_in = pngcp_pkg::PH_CRC;
               count_in = '0;
               crc_in   = '0;
            end else begin
               count_in = count_plus;
            end
         end
         pngcp_pkg::PH_CRC: begin
            crc_in = {crc_cur[23:0], file_byte};
            if (count_plus == pngcp_pkg::WORD_BYTES) begin
               op.op     = pngcp_pkg::OP_COMPLETE;
               op.kind   = kind_ff;
               op.length = len_cur;
               op.crc    = {crc_cur[23:0], file_byte};
               count_in  = '0;
               if (kind_ff == pngcp_pkg::KIND_IEND) begin
                  phase_in = pngcp_pkg::PH_DONE;
               end else begin
                  phase_in = pngcp_pkg::PH_LEN;
                  len_in   = '0;
               end
            end else begin
               count_in = count_plus;
            end
         end
         default: begin
            // Done or bad signature: drop the byte
            phase_in = phase_cur;
         end
      endcase
   end

   // Queue only bytes that leave work for the back end
   assign push      = accept && (start_of_file || (op.op != pngcp_pkg::OP_NONE));
   assign push_data = op;

endmodule

// ----- src/pngcp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngcp_queue - short record queue between front end and back end
// Register-based first-in first-out store with a visible head entry.
// ----------------------------------------------------------------------------
module pngcp_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pngcp_pkg::op_type push_data,
   output logic              full,
   input  logic              pop,
   output pngcp_pkg::op_type head,
   output logic              empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   pngcp_pkg::op_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign do_push = push && (count_ff != CW'(DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   // Advance pointers and fill count
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Store the pushed record
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   assign head  = entry_ff[rd_ff];
   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

// ----- src/pngcp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngcp_back - header capture and result stage of the PNG chunk stream parser
// Applies IHDR records to the captured image header and builds result beats
// in an output register.
// ----------------------------------------------------------------------------
module pngcp_back (
   input  logic               clock,
   input  logic               reset,
   input  pngcp_pkg::op_type  head,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_pop,
   output pngcp_pkg::rsp_type rsp
);

   logic [31:0] width_ff, width_in, width_cur;
   logic [31:0] height_ff, height_in, height_cur;
   logic [7:0]  hdr_ff [pngcp_pkg::HDR_BYTES];
   logic [7:0]  hdr_in [pngcp_pkg::HDR_BYTES];
   logic        valid_ff, valid_in;
   pngcp_pkg::rsp_type rsp_ff, rsp_in;
   logic        emits;
   logic [1:0]  ev;

   // Classify the head record
   always_comb begin
      emits = 1'b1;
      ev    = pngcp_pkg::EV_MISMATCH;
      case (head.op)
         pngcp_pkg::OP_MISMATCH: ev = pngcp_pkg::EV_MISMATCH;
         pngcp_pkg::OP_PAYLOAD:  ev = pngcp_pkg::EV_PAYLOAD;
         pngcp_pkg::OP_COMPLETE: ev = pngcp_pkg::EV_COMPLETE;
         default:                emits = 1'b0;
      endcase
   end

   // Drain header-only records at once, result records when the slot frees
   assign q_pop = !q_empty && (!emits || !valid_ff || rsp_pop);

   // Apply clear and header update, then build the beat
   always_comb begin
      width_cur  = head.clear ? '0 : width_ff;
      height_cur = head.clear ? '0 : height_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      for (int i = 0; i < pngcp_pkg::HDR_BYTES; i++) begin
         hdr_in[i] = hdr_ff[i];
      end
      if (q_pop) begin
         width_in  = width_cur;
         height_in = height_cur;
         for (int i = 0; i < pngcp_pkg::HDR_BYTES; i++) begin
            hdr_in[i] = head.clear ? 8'd0 : hdr_ff[i];
            if ((head.op == pngcp_pkg::OP_HDR_BYTE) && (head.hdr_idx == 3'(i))) begin
               hdr_in[i] = head.data;
            end
         end
         if (head.op == pngcp_pkg::OP_WIDTH) begin
            width_in = {width_cur[23:0], head.data};
         end
         if (head.op == pngcp_pkg::OP_HEIGHT) begin
            height_in = {height_cur[23:0], head.data};
         end
      end

      rsp_in.event_res          = ev;
      rsp_in.chunk_kind         = head.kind;
      rsp_in.chunk_length       = head.length;
      rsp_in.payload_byte       = head.data;
      rsp_in.chunk_crc          = head.crc;
      rsp_in.image_width        = width_in;
      rsp_in.image_height       = height_in;
      rsp_in.bit_depth          = hdr_in[0];
      rsp_in.color_kind         = hdr_in[1];
      rsp_in.compression_method = hdr_in[2];
      rsp_in.filter_method      = hdr_in[3];
      rsp_in.interlace_method   = hdr_in[4];

      if (q_pop && emits) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Hold captured header
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         for (int i = 0; i < pngcp_pkg::HDR_BYTES; i++) begin
            hdr_ff[i] <= '0;
         end
         valid_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         for (int i = 0; i < pngcp_pkg::HDR_BYTES; i++) begin
            hdr_ff[i] <= hdr_in[i];
         end
         valid_ff  <= valid_in;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (q_pop && emits) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- src/png_chunk_stream_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_chunk_stream_parser - PNG signature check and chunk framer
// Takes a PNG file one byte a beat and reports signature errors, payload
// bytes of PLTE, IDAT and IEND, and every completed chunk.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive req_file_byte and req_start_of_file with
//   req_push; a beat is taken when req_push is high and req_full is low.
//   Raise req_start_of_file on the first byte of a file to clear all parse
//   state and the captured header.
//   Result side is a queue: the oldest result sits on the rsp_ ports while
//   rsp_empty is low and leaves on a cycle with rsp_pop high.
//   A result passes through the record queue and then the output register
//   before it shows on the rsp_ ports.
//   Throughput: one byte per cycle while req_full is low; bytes that give
//   no result never occupy the output register.
//   When the receiver stalls, results wait in the output register and the
//   record queue (QUEUE_DEPTH entries); req_full rises once the queue fills.
//   After reset the parser waits for signature byte 0 with an empty header.
//   After IEND or a signature mismatch, bytes are dropped until a new start.
// ----------------------------------------------------------------------------
module png_chunk_stream_parser #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_file_byte,
   input  logic        req_start_of_file,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_event_res,
   output logic [2:0]  rsp_chunk_kind,
   output logic [31:0] rsp_chunk_length,
   output logic [7:0]  rsp_payload_byte,
   output logic [31:0] rsp_chunk_crc,
   output logic [31:0] rsp_image_width,
   output logic [31:0] rsp_image_height,
   output logic [7:0]  rsp_bit_depth,
   output logic [7:0]  rsp_color_kind,
   output logic [7:0]  rsp_compression_method,
   output logic [7:0]  rsp_filter_method,
   output logic [7:0]  rsp_interlace_method
);

   logic                accept;
   logic                q_push, q_full, q_pop, q_empty;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
   pngcp_pkg::op_type   q_in, q_head;
   pngcp_pkg::rsp_type  rsp;
   logic                rsp_valid;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   // Frame the byte stream
   pngcp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .file_byte     (req_file_byte),
      .start_of_file (req_start_of_file),
      .push          (q_push),
      .push_data     (q_in)
   );

   // Decouple framer from result stage
   pngcp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .count     (q_count)
   );

   // Capture header and build results
   pngcp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_empty              = !rsp_valid;
   assign rsp_event_res          = rsp.event_res;
   assign rsp_chunk_kind         = rsp.chunk_kind;
   assign rsp_chunk_length       = rsp.chunk_length;
   assign rsp_payload_byte       = rsp.payload_byte;
   assign rsp_chunk_crc          = rsp.chunk_crc;
   assign rsp_image_width        = rsp.image_width;
   assign rsp_image_height       = rsp.image_height;
   assign rsp_bit_depth          = rsp.bit_depth;
   assign rsp_color_kind         = rsp.color_kind;
   assign rsp_compression_method = rsp.compression_method;
   assign rsp_filter_method      = rsp.filter_method;
   assign rsp_interlace_method   = rsp.interlace_method;

   // The framer never pushes into a full queue
   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("record pushed into full queue");

   // Fill count stays within the queue depth
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
      else $error("queue fill count out of range");

   // A start-of-file beat always leaves a clear record queued
   a_start_queued : assert property (@(posedge clock) disable iff (reset)
      (accept && req_start_of_file) |=> !q_empty)
      else $error("start of file record lost");

   // A shown result never carries an unused event code
   a_event_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_res == pngcp_pkg::EV_MISMATCH ||
                     rsp_event_res == pngcp_pkg::EV_PAYLOAD ||
                     rsp_event_res == pngcp_pkg::EV_COMPLETE))
      else $error("invalid event code on result");

endmodule

// ----- tb/tb_png_chunk_stream_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_png_chunk_stream_parser - self-checking bench for the PNG chunk parser
// Feeds byte streams through the push/full port: a directed set of corner
// files, then random files, most of them well formed and some broken, under
// several idle patterns and one long receiver hold-off. A behavioural model of
// the framer predicts every result beat, and the pop side compares each beat
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_png_chunk_stream_parser;

   // Signature bytes, first byte in the top lane
   localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;
   // Signature fault position meaning a clean signature
   localparam int NO_FAULT = 8;
   localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;

   typedef struct packed {
      logic [7:0] data;
      logic       sof;
   } file_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_file_byte = 8'd0;
   logic        req_start_of_file = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_event_res;
   logic [2:0]  rsp_chunk_kind;
   logic [31:0] rsp_chunk_length;
   logic [7:0]  rsp_payload_byte;
   logic [31:0] rsp_chunk_crc;
   logic [31:0] rsp_image_width;
   logic [31:0] rsp_image_height;
   logic [7:0]  rsp_bit_depth;
   logic [7:0]  rsp_color_kind;
   logic [7:0]  rsp_compression_method;
   logic [7:0]  rsp_filter_method;
   logic [7:0]  rsp_interlace_method;

   // Stimulus and checking state
   file_beat_type       tx_queue[$];
   pngcp_pkg::rsp_type  expected_beats[$];
   int unsigned send_gap_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned stim_bytes = 0;
   int unsigned mismatch_count = 0;
   logic        hold_go = 1'b0;
   logic        rx_hold = 1'b0;

   // Shadow parse state
   pngcp_pkg::phase_type parse_phase;
   logic [31:0] frame_count;
   logic [31:0] len_word;
   logic [31:0] type_word;
   logic [31:0] crc_word;
   logic [31:0] width_word;
   logic [31:0] height_word;
   logic [7:0]  hdr_q [pngcp_pkg::HDR_BYTES];

   png_chunk_stream_parser dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_push               (req_push),
      .req_full               (req_full),
      .req_file_byte          (req_file_byte),
      .req_start_of_file      (req_start_of_file),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_event_res          (rsp_event_res),
      .rsp_chunk_kind         (rsp_chunk_kind),
      .rsp_chunk_length       (rsp_chunk_length),
      .rsp_payload_byte       (rsp_payload_byte),
      .rsp_chunk_crc          (rsp_chunk_crc),
      .rsp_image_width        (rsp_image_width),
      .rsp_image_height       (rsp_image_height),
      .rsp_bit_depth          (rsp_bit_depth),
      .rsp_color_kind         (rsp_color_kind),
      .rsp_compression_method (rsp_compression_method),
      .rsp_filter_method      (rsp_filter_method),
      .rsp_interlace_method   (rsp_interlace_method)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Frame model
   // ------------------------------------------------------------------------
   function automatic logic [2:0] chunk_class(input logic [31:0] word);
      logic [2:0] k;
      case (word)
         pngcp_pkg::TYPE_IHDR: k = pngcp_pkg::KIND_IHDR;
         pngcp_pkg::TYPE_PLTE: k = pngcp_pkg::KIND_PLTE;
         pngcp_pkg::TYPE_IDAT: k = pngcp_pkg::KIND_IDAT;
         pngcp_pkg::TYPE_IEND: k = pngcp_pkg::KIND_IEND;
         default:              k = pngcp_pkg::KIND_OTHER;
      endcase
      return k;
   endfunction

   // Build a beat that carries the header captured so far
   function automatic pngcp_pkg::rsp_type beat_with_header(input logic [1:0] ev,
                                                           input logic [2:0] kind,
                                                           input logic [31:0] len,
                                                           input logic [7:0] pb,
                                                           input logic [31:0] crc);
      pngcp_pkg::rsp_type b;
      b.event_res          = ev;
      b.chunk_kind         = kind;
      b.chunk_length       = len;
      b.payload_byte       = pb;
      b.chunk_crc          = crc;
      b.image_width        = width_word;
      b.image_height       = height_word;
      b.bit_depth          = hdr_q[0];
      b.color_kind         = hdr_q[1];
      b.compression_method = hdr_q[2];
      b.filter_method      = hdr_q[3];
      b.interlace_method   = hdr_q[4];
      return b;
   endfunction

   task automatic clear_parse();
      parse_phase = pngcp_pkg::PH_SIG;
      frame_count = '0;
      len_word    = '0;
      type_word   = '0;
      crc_word    = '0;
      width_word  = '0;
      height_word = '0;
      for (int i = 0; i < pngcp_pkg::HDR_BYTES; i++) hdr_q[i] = 8'd0;
   endtask

   // Advance the model by one accepted byte and queue any result it causes
   task automatic frame_byte(input logic [7:0] b, input logic sof);
      logic [2:0] k;
      int         pos;
      if (sof) clear_parse();
      case (parse_phase)
         pngcp_pkg::PH_SIG: begin
            pos = int'(frame_count[2:0]);
            if (b != PNG_MAGIC[8*(7 - pos) +: 8]) begin
               parse_phase = pngcp_pkg::PH_BAD;
               // kind, length, payload and CRC all read zero on a fault
               expected_beats.push_back(beat_with_header(pngcp_pkg::EV_MISMATCH,
                                                         pngcp_pkg::KIND_IHDR,
                                                         32'd0, 8'd0, 32'd0));
            end else begin
               frame_count++;
               if (frame_count >= pngcp_pkg::SIG_BYTES) begin
                  parse_phase = pngcp_pkg::PH_LEN;
                  frame_count = '0;
                  len_word    = '0;
               end
            end
         end
         pngcp_pkg::PH_LEN: begin
            len_word = {len_word[23:0], b};
            frame_count++;
            if (frame_count >= pngcp_pkg::WORD_BYTES) begin
               parse_phase = pngcp_pkg::PH_TYPE;
               frame_count = '0;
               type_word   = '0;
            end
         end
         pngcp_pkg::PH_TYPE: begin
            type_word = {type_word[23:0], b};
            frame_count++;
            if (frame_count >= pngcp_pkg::WORD_BYTES) begin
               frame_count = '0;
               crc_word    = '0;
               parse_phase = (len_word == 32'd0) ? pngcp_pkg::PH_CRC : pngcp_pkg::PH_DATA;
            end
         end
         pngcp_pkg::PH_DATA: begin
            k = chunk_class(type_word);
            if (k == pngcp_pkg::KIND_IHDR) begin
               if (frame_count < pngcp_pkg::IHDR_HEIGHT_AT) begin
                  width_word = {width_word[23:0], b};
               end else if (frame_count < pngcp_pkg::IHDR_BYTES_AT) begin
                  height_word = {height_word[23:0], b};
               end else if (frame_count < pngcp_pkg::IHDR_END_AT) begin
                  hdr_q[3'(frame_count - pngcp_pkg::IHDR_BYTES_AT)] = b;
               end
            end else if (k != pngcp_pkg::KIND_OTHER) begin
               expected_beats.push_back(beat_with_header(pngcp_pkg::EV_PAYLOAD, k,
                                                         len_word, b, 32'd0));
            end
            frame_count++;
            if (frame_count >= len_word) begin
               parse_phase = pngcp_pkg::PH_CRC;
               frame_count = '0;
               crc_word    = '0;
            end
         end
         pngcp_pkg::PH_CRC: begin
            crc_word = {crc_word[23:0], b};
            frame_count++;
            if (frame_count >= pngcp_pkg::WORD_BYTES) begin
               k = chunk_class(type_word);
               expected_beats.push_back(beat_with_header(pngcp_pkg::EV_COMPLETE, k,
                                                         len_word, 8'd0, crc_word));
               frame_count = '0;
               if (k == pngcp_pkg::KIND_IEND) begin
                  parse_phase = pngcp_pkg::PH_DONE;
               end else begin
                  parse_phase = pngcp_pkg::PH_LEN;
                  len_word    = '0;
               end
            end
         end
         default: begin
            // done or faulted: drop the byte
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t ns: %s got %h want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // Predict on every accepted byte, compare on every popped beat
   always @(posedge clock) begin : result_monitor
      pngcp_pkg::rsp_type want;
      if (reset) begin
         clear_parse();
      end else begin
         if (req_push && !req_full) frame_byte(req_file_byte, req_start_of_file);
         if (rsp_pop && !rsp_empty) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("unexpected beat, event", 32'(rsp_event_res), 32'd0);
            end else begin
               want = expected_beats.pop_front();
               check_field("event_res", 32'(rsp_event_res), 32'(want.event_res));
               check_field("chunk_kind", 32'(rsp_chunk_kind), 32'(want.chunk_kind));
               check_field("chunk_length", rsp_chunk_length, want.chunk_length);
               check_field("payload_byte", 32'(rsp_payload_byte), 32'(want.payload_byte));
               check_field("chunk_crc", rsp_chunk_crc, want.chunk_crc);
               check_field("image_width", rsp_image_width, want.image_width);
               check_field("image_height", rsp_image_height, want.image_height);
               check_field("bit_depth", 32'(rsp_bit_depth), 32'(want.bit_depth));
               check_field("color_kind", 32'(rsp_color_kind), 32'(want.color_kind));
               check_field("compression_method", 32'(rsp_compression_method),
                           32'(want.compression_method));
               check_field("filter_method", 32'(rsp_filter_method),
                           32'(want.filter_method));
               check_field("interlace_method", 32'(rsp_interlace_method),
                           32'(want.interlace_method));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   // Retire the accepted byte, then offer the next one unless idling
   always @(posedge clock) begin : byte_driver
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) void'(tx_queue.pop_front());
         if (tx_queue.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
            req_push          <= 1'b1;
            req_file_byte     <= tx_queue[0].data;
            req_start_of_file <= tx_queue[0].sof;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Pop results, stalling at random or through the hold-off
   always @(posedge clock) begin : result_popper
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= !rx_hold && ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // Long receiver hold-off so that the parser backs up and raises full
   initial begin : rx_hold_off
      wait (hold_go);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic put(input logic [7:0] b, input logic sof);
      file_beat_type fb;
      fb.data = b;
      fb.sof  = sof;
      tx_queue.push_back(fb);
      stim_bytes++;
   endtask

   task automatic put_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) put(w[8*i +: 8], 1'b0);
   endtask

   // Signature, optionally with one bit flipped at position fault_at
   task automatic put_sig(input logic sof, input int fault_at);
      logic [7:0] b;
      for (int i = 0; i < 8; i++) begin
         b = PNG_MAGIC[8*(7 - i) +: 8];
         if (i == fault_at) b = b ^ (8'h01 << $urandom_range(7, 0));
         put(b, sof && (i == 0));
      end
   endtask

   task automatic put_chunk(input logic [31:0] kind_word, input int unsigned len);
      put_word(32'(len));
      put_word(kind_word);
      repeat (len) put(8'($urandom), 1'b0);
      put_word($urandom);
   endtask

   // One random file: mostly well formed, some noise and broken streams
   task automatic put_random_file();
      int unsigned pick;
      int unsigned n;
      int unsigned len;
      int unsigned sel;
      logic [31:0] kind_word;
      pick = $urandom_range(9, 0);
      if (pick == 0) begin
         put(8'($urandom), 1'b1);
         repeat ($urandom_range(6, 1)) put(8'($urandom), $urandom_range(7, 0) == 0);
      end else begin
         put_sig(pick != 9, (pick == 1) ? int'($urandom_range(7, 0)) : NO_FAULT);
         n = $urandom_range(4, 0);
         repeat (n) begin
            sel = $urandom_range(3, 0);
            len = ($urandom_range(19, 0) == 0) ? $urandom_range(40, 0)
                                               : $urandom_range(10, 0);
            case (sel)
               0: begin
                  kind_word = pngcp_pkg::TYPE_IHDR;
                  if ($urandom_range(3, 0) != 0) len = pngcp_pkg::IHDR_END_AT;
               end
               1: kind_word = pngcp_pkg::TYPE_PLTE;
               2: kind_word = pngcp_pkg::TYPE_IDAT;
               default: kind_word = $urandom;
            endcase
            put_chunk(kind_word, len);
         end
         // truncate now and then, otherwise close with IEND and some junk
         if ($urandom_range(7, 0) != 0) begin
            put_chunk(pngcp_pkg::TYPE_IEND,
                      ($urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : 0);
            repeat ($urandom_range(2, 0)) put(8'($urandom), 1'b0);
         end
      end
   endtask

   // Hold until every byte is taken and every result has come back
   task automatic drain();
      while (tx_queue.size() != 0 || expected_beats.size() != 0) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned goal;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_gap_pct   = 20;
      recv_stall_pct = 20;
      // stream begins without a start mark
      put_sig(1'b0, NO_FAULT);
      // zero-length chunk of an unknown type: CRC follows the type
      put_word(32'd0);
      put_word(TYPE_TEXT);
      put_word(32'hFFFF_FFFF);
      // IHDR with field extremes
      put_word(32'd13);
      put_word(pngcp_pkg::TYPE_IHDR);
      put_word(32'hFFFF_FFFF);
      put_word(32'h0000_0000);
      put(8'hFF, 1'b0);
      put(8'h00, 1'b0);
      put(8'h80, 1'b0);
      put(8'h01, 1'b0);
      put(8'h7F, 1'b0);
      put_word(32'h0000_0000);
      // short IHDR keeps the rest, long IHDR drops its tail
      put_word(32'd5);
      put_word(pngcp_pkg::TYPE_IHDR);
      put_word(32'h1234_5678);
      put(8'hAB, 1'b0);
      put_word(32'h5A5A_A5A5);
      put_chunk(pngcp_pkg::TYPE_IHDR, 15);
      // palette, image data and a skipped chunk
      put_word(32'd3);
      put_word(pngcp_pkg::TYPE_PLTE);
      put(8'h00, 1'b0);
      put(8'hFF, 1'b0);
      put(8'h5A, 1'b0);
      put_word(32'h8000_0001);
      put_chunk(pngcp_pkg::TYPE_IDAT, 2);
      put_chunk(TYPE_TEXT, 2);
      // IEND with a payload, then bytes after it are dropped
      put_chunk(pngcp_pkg::TYPE_IEND, 1);
      put(8'd137, 1'b0);
      put(8'd80, 1'b0);
      // signature fault on the last byte, then on the first
      put_sig(1'b1, 7);
      put(8'h00, 1'b0);
      put(8'h00, 1'b1);
      put(8'd137, 1'b0);
      // restart in the middle of a huge IDAT
      put_sig(1'b1, NO_FAULT);
      put_word(32'hFFFF_FFFE);
      put_word(pngcp_pkg::TYPE_IDAT);
      repeat (3) put(8'($urandom), 1'b0);
      put_sig(1'b1, NO_FAULT);
      put_chunk(pngcp_pkg::TYPE_IEND, 0);
      drain();

      // random files under each idle pattern
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 55; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 55; end
            default: begin send_gap_pct = 27; recv_stall_pct = 27; end
         endcase
         goal = stim_bytes + 20;
         while (stim_bytes < goal) put_random_file();
         drain();
      end

      // back-pressure: keep offering while the receiver holds off
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      hold_go        = 1'b1;
      put_sig(1'b1, NO_FAULT);
      put_chunk(pngcp_pkg::TYPE_IDAT, 40);
      put_chunk(pngcp_pkg::TYPE_IEND, 0);
      drain();

      repeat (10) @(negedge clock);
      if (expected_beats.size() != 0) begin
         report_mismatch("beats never returned", expected_beats.size(), 32'd0);
      end
      if (mismatch_count == 0) begin
         $display("png_chunk_stream_parser: match");
      end else begin
         $display("png_chunk_stream_parser: mismatch");
      end
      $finish;
   end

   // Watchdog
   initial begin : run_limit
      #2_000_000;
      $display("png_chunk_stream_parser: mismatch");
      $finish;
   end

endmodule

// ----- files.f -----
src/pngcp_pkg.sv
src/pngcp_front.sv
src/pngcp_queue.sv
src/pngcp_back.sv
src/png_chunk_stream_parser.sv
tb/tb_png_chunk_stream_parser.sv
